@@ rtl/assert_macros.svh @@
// assertion macros shared by the timer bank rtl
// no dependencies; assertions drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked assertion, disabled while reset is high
`define ODT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ODT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ODT_ASSERT(lbl, clk, rst, prop, msg)
`define ODT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/odt_pkg.sv @@
// shared types and constants for the on/off delay timer bank
// no dependencies
package odt_pkg;

   // fixed field widths
   localparam int DELAY_W   = 16;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 4;
   localparam int TIDX_W    = 3;
   localparam int FLAG_W    = 8;

   // parameter defaults
   localparam int NUM_TIMERS_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 16;

   // operation codes
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // single-bit state fields of a timer
   typedef struct packed {
      logic level;
      logic on_flag;
      logic off_flag;
   } timer_bits_type;

   // command to the update unit
   typedef struct packed {
      logic is_tick;
      logic set_level;
   } unit_cmd_type;

endpackage

@@ rtl/odt_unit.sv @@
// shared update unit: next state of one timer for a set or a tick step
// depends on odt_pkg
module odt_unit import odt_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  unit_cmd_type             cmd,
   input  timer_bits_type           cur,
   input  logic [COUNT_WIDTH-1:0]   on_cnt,
   input  logic [COUNT_WIDTH-1:0]   off_cnt,
   input  logic [COUNT_WIDTH-1:0]   delay,
   output timer_bits_type           nxt,
   output logic [COUNT_WIDTH-1:0]   on_cnt_nxt,
   output logic [COUNT_WIDTH-1:0]   off_cnt_nxt
);

   logic [COUNT_WIDTH-1:0] active;
   logic [COUNT_WIDTH-1:0] act_dec;
   logic                   act_zero;
   logic                   dly_zero;

   // one decrementer and zero test on the counter that the level selects
   assign active   = cur.level ? on_cnt : off_cnt;
   assign act_dec  = active - 1'b1;
   assign act_zero = (active == '0);
   assign dly_zero = (delay == '0);

   always_comb begin
      nxt         = cur;
      on_cnt_nxt  = on_cnt;
      off_cnt_nxt = off_cnt;
      if (cmd.is_tick) begin
         // tick: run the active counter, preload the other one
         if (cur.level) begin
            if (!act_zero) begin
               on_cnt_nxt  = act_dec;
               nxt.on_flag = 1'b0;
            end else begin
               nxt.on_flag = 1'b1;
            end
            off_cnt_nxt = delay;
         end else begin
            if (!act_zero) begin
               off_cnt_nxt  = act_dec;
               nxt.off_flag = 1'b1;
            end else begin
               nxt.off_flag = 1'b0;
            end
            on_cnt_nxt = delay;
         end
      end else begin
         // set: store level, preload the opposite counter
         nxt.level = cmd.set_level;
         if (cmd.set_level) begin
            off_cnt_nxt  = delay;
            nxt.off_flag = 1'b1;
            if (dly_zero) begin
               nxt.on_flag = 1'b1;
            end
         end else begin
            on_cnt_nxt  = delay;
            nxt.on_flag = 1'b0;
            if (dly_zero) begin
               nxt.off_flag = 1'b0;
            end
         end
      end
   end

endmodule

@@ rtl/on_off_delay_timer_bank_core.sv @@
// on/off delay timer bank, top level; depends on odt_pkg, odt_unit, assert_macros.svh
// req channel (valid/stall): operation, timer_index, level. A set beat stores
// one timer's level; a tick beat sweeps every timer through the shared update
// unit, one timer per cycle. Every req beat gives exactly one rsp beat with
// both flag vectors (bits at and above NUM_TIMERS read zero).
// csr channel (valid/ready, always ready): index 0..7 writes delay_i, other
// indexes are dropped. Write only while the bank is idle.
// A tick beat passes through the work state once per timer and then the done
// state; a set beat takes one work step, and a set to a timer beyond the bank
// goes straight to the done state. req_stall is high whenever the sequencer
// is out of idle, so a new item is taken only after the last one has loaded
// its result into the rsp register.
// The rsp register parts the channels: a new item is taken while an old
// result waits, and the next result holds in the done step until the
// receiver drops rsp_stall. Reset (synchronous) clears all timers, delays
// and rsp_valid.
`include "assert_macros.svh"

module on_off_delay_timer_bank_core import odt_pkg::*; #(
   parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [TIDX_W-1:0]     req_timer_index,
   input  logic                  req_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FLAG_W-1:0]     rsp_on_delayed_flags,
   output logic [FLAG_W-1:0]     rsp_off_delayed_flags,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [DELAY_W-1:0]    csr_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int EXT_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WORK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // sequencer
   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic                   is_tick_ff, is_tick_in;
   logic                   set_level_ff, set_level_in;

   // timer state
   logic [DELAY_W-1:0]     delay_ff [NUM_REGS];
   logic [COUNT_WIDTH-1:0] on_cnt_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] off_cnt_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  level_ff, on_flag_ff, off_flag_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0]      rsp_on_ff, rsp_on_in;
   logic [FLAG_W-1:0]      rsp_off_ff, rsp_off_in;

   logic                   req_fire;
   logic                   set_in_range;
   logic                   last_step;
   logic                   slot_free;
   logic [EXT_W-1:0]       delay_ext;
   logic [COUNT_WIDTH-1:0] delay_cnt;
   unit_cmd_type           cmd;
   timer_bits_type         cur_bits, nxt_bits;
   logic [COUNT_WIDTH-1:0] on_cnt_nxt, off_cnt_nxt;

   assign req_fire     = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign set_in_range = ({1'b0, req_timer_index} < (TIDX_W + 1)'(NUM_TIMERS));
   assign last_step    = !is_tick_ff || (cur_idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign slot_free    = !rsp_valid_ff || !rsp_stall;

   // delay of the timer in work, fitted to the counter width
   assign delay_ext = EXT_W'(delay_ff[cur_idx_ff]);
   assign delay_cnt = delay_ext[COUNT_WIDTH-1:0];

   assign cmd.is_tick    = is_tick_ff;
   assign cmd.set_level  = set_level_ff;
   assign cur_bits.level    = level_ff[cur_idx_ff];
   assign cur_bits.on_flag  = on_flag_ff[cur_idx_ff];
   assign cur_bits.off_flag = off_flag_ff[cur_idx_ff];

   odt_unit #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_unit (
      .cmd         (cmd),
      .cur         (cur_bits),
      .on_cnt      (on_cnt_ff[cur_idx_ff]),
      .off_cnt     (off_cnt_ff[cur_idx_ff]),
      .delay       (delay_cnt),
      .nxt         (nxt_bits),
      .on_cnt_nxt  (on_cnt_nxt),
      .off_cnt_nxt (off_cnt_nxt)
   );

   // sequencer next state and result load
   always_comb begin
      state_in     = state_ff;
      cur_idx_in   = cur_idx_ff;
      is_tick_in   = is_tick_ff;
      set_level_in = set_level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_on_in    = rsp_on_ff;
      rsp_off_in   = rsp_off_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_tick_in   = (req_operation == OP_TICK);
               set_level_in = req_level;
               if (req_operation == OP_TICK) begin
                  cur_idx_in = '0;
                  state_in   = ST_WORK;
               end else begin
                  cur_idx_in = req_timer_index[IDX_W-1:0];
                  state_in   = set_in_range ? ST_WORK : ST_DONE;
               end
            end
         end
         ST_WORK: begin
            if (last_step) begin
               state_in = ST_DONE;
            end else begin
               cur_idx_in = cur_idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_on_in    = FLAG_W'(on_flag_ff);
               rsp_off_in   = FLAG_W'(off_flag_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_idx_ff   <= '0;
         is_tick_ff   <= 1'b0;
         set_level_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_idx_ff   <= cur_idx_in;
         is_tick_ff   <= is_tick_in;
         set_level_ff <= set_level_in;
      end
      rsp_on_ff  <= rsp_on_in;
      rsp_off_ff <= rsp_off_in;
   end

   // delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready &&
                   ({1'b0, csr_index} < (REG_IDX_W + 1)'(NUM_REGS))) begin
         delay_ff[csr_index[$clog2(NUM_REGS)-1:0]] <= csr_data;
      end
   end

   // timer state, one timer written per work step
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         on_flag_ff  <= '0;
         off_flag_ff <= '0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            on_cnt_ff[i]  <= '0;
            off_cnt_ff[i] <= '0;
         end
      end else if (state_ff == ST_WORK) begin
         level_ff[cur_idx_ff]    <= nxt_bits.level;
         on_flag_ff[cur_idx_ff]  <= nxt_bits.on_flag;
         off_flag_ff[cur_idx_ff] <= nxt_bits.off_flag;
         on_cnt_ff[cur_idx_ff]   <= on_cnt_nxt;
         off_cnt_ff[cur_idx_ff]  <= off_cnt_nxt;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_on_delayed_flags  = rsp_on_ff;
   assign rsp_off_delayed_flags = rsp_off_ff;

   // checks
   `ODT_ASSERT(a_accept_leaves_idle, clock, reset,
      req_fire |=> (state_ff != ST_IDLE), "accepted beat did not start work")
   `ODT_ASSERT(a_work_idx_range, clock, reset,
      (state_ff == ST_WORK) |-> ({1'b0, cur_idx_ff} < (IDX_W + 1)'(NUM_TIMERS)),
      "work step addresses a timer beyond the bank")
   `ODT_ASSERT(a_done_delivers, clock, reset,
      ((state_ff == ST_DONE) && slot_free) |=> ((state_ff == ST_IDLE) && rsp_valid_ff),
      "done step did not load the result")
   `ODT_ASSERT(a_unused_flags_zero, clock, reset,
      rsp_valid_ff |-> (((rsp_on_ff >> NUM_TIMERS) == '0) &&
                        ((rsp_off_ff >> NUM_TIMERS) == '0)),
      "flag bit set for a timer beyond the bank")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for on_off_delay_timer_bank_core; depends on odt_pkg
// keeps a mirror of every timer, predicts the flag vectors of each req beat and
// compares them with the rsp beats; directed cases first, then random phases

module testbench;
   import odt_pkg::*;

   localparam int TIMERS       = NUM_TIMERS_DEF;
   localparam int CNT_W        = COUNT_WIDTH_DEF;
   localparam int SETTLE_CYC   = TIMERS + 6;
   localparam int STALL_LIMIT  = 2000;
   localparam int IDLE_PCT     = 14;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASES       = 8;
   localparam int STEADY_PHASE = 3;

   typedef struct packed {
      logic [FLAG_W-1:0] on_flags;
      logic [FLAG_W-1:0] off_flags;
   } flag_pair_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_operation   = OP_SET;
   logic [TIDX_W-1:0]    req_timer_index = '0;
   logic                 req_level       = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [FLAG_W-1:0]    rsp_on_delayed_flags;
   logic [FLAG_W-1:0]    rsp_off_delayed_flags;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [REG_IDX_W-1:0] csr_index       = '0;
   logic [DELAY_W-1:0]   csr_data        = '0;

   // mirror of the bank
   logic [DELAY_W-1:0] delay_regs [NUM_REGS];
   logic               level_q    [TIMERS];
   logic [CNT_W-1:0]   on_count   [TIMERS];
   logic [CNT_W-1:0]   off_count  [TIMERS];
   logic               on_flag    [TIMERS];
   logic               off_flag   [TIMERS];

   flag_pair_type pending_flags [$];
   int            error_count  = 0;
   int            quiet_cycles = 0;
   bit            steady       = 1'b0;

   on_off_delay_timer_bank_core #(
      .NUM_TIMERS  (TIMERS),
      .COUNT_WIDTH (CNT_W)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_timer_index       (req_timer_index),
      .req_level             (req_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_on_delayed_flags  (rsp_on_delayed_flags),
      .rsp_off_delayed_flags (rsp_off_delayed_flags),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void clear_mirror();
      for (int i = 0; i < NUM_REGS; i++) delay_regs[i] = '0;
      for (int t = 0; t < TIMERS; t++) begin
         level_q[t]   = 1'b0;
         on_count[t]  = '0;
         off_count[t] = '0;
         on_flag[t]   = 1'b0;
         off_flag[t]  = 1'b0;
      end
   endfunction

   // apply one req beat to the mirror and return the flags it should report
   function automatic flag_pair_type advance_timers(input logic op,
                                                    input logic [TIDX_W-1:0] idx,
                                                    input logic lvl);
      flag_pair_type    res;
      logic [CNT_W-1:0] dly;
      res = '0;
      if (op == OP_TICK) begin
         for (int t = 0; t < TIMERS; t++) begin
            dly = delay_regs[t][CNT_W-1:0];
            if (level_q[t]) begin
               if (on_count[t] != '0) begin
                  on_count[t] = on_count[t] - 1'b1;
                  on_flag[t]  = 1'b0;
               end else begin
                  on_flag[t] = 1'b1;
               end
               off_count[t] = dly;
            end else begin
               if (off_count[t] != '0) begin
                  off_count[t] = off_count[t] - 1'b1;
                  off_flag[t]  = 1'b1;
               end else begin
                  off_flag[t] = 1'b0;
               end
               on_count[t] = dly;
            end
         end
      end else if (idx < TIMERS) begin
         dly          = delay_regs[idx][CNT_W-1:0];
         level_q[idx] = lvl;
         if (lvl) begin
            off_count[idx] = dly;
            off_flag[idx]  = 1'b1;
            if (dly == '0) on_flag[idx] = 1'b1;
         end else begin
            on_count[idx] = dly;
            on_flag[idx]  = 1'b0;
            if (dly == '0) off_flag[idx] = 1'b0;
         end
      end
      for (int t = 0; t < TIMERS; t++) begin
         res.on_flags[t]  = on_flag[t];
         res.off_flags[t] = off_flag[t];
      end
      return res;
   endfunction

   // one req beat; valid stays up unless a random gap follows
   task automatic send_item(input logic op, input logic [TIDX_W-1:0] idx, input logic lvl);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_timer_index <= idx;
      req_level       <= lvl;
      do @(posedge clock); while (req_stall);
      pending_flags.push_back(advance_timers(op, idx, lvl));
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic write_delay(input logic [REG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_REGS) delay_regs[idx] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold off the sender until every expected beat is back and the bank is quiet
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // tick and set straight out of reset, all delays zero
   task automatic test_reset_state();
      send_item(OP_TICK, 3'd5, 1'b1);
      send_item(OP_SET, 3'd0, 1'b1);
      send_item(OP_TICK, 3'd0, 1'b0);
      wait_for_idle();
   endtask

   // zero delay: flags follow the level at once
   task automatic test_zero_delay();
      send_item(OP_SET, 3'd7, 1'b1);
      send_item(OP_SET, 3'd3, 1'b1);
      send_item(OP_TICK, 3'd7, 1'b0);
      send_item(OP_SET, 3'd7, 1'b0);
      send_item(OP_SET, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd2, 1'b1);
      wait_for_idle();
   endtask

   // full-scale and one-tick delays, writes to unused register indexes
   task automatic test_extreme_delays();
      write_delay(4'd0, 16'hFFFF);
      write_delay(4'd1, 16'h0001);
      write_delay(4'd2, 16'h0002);
      write_delay(4'd3, 16'hAAAA);
      write_delay(4'd4, 16'h5555);
      write_delay(4'd5, 16'h0000);
      write_delay(4'd6, 16'h8000);
      write_delay(4'd7, 16'hFFFF);
      for (int i = NUM_REGS; i < 2 ** REG_IDX_W; i++) write_delay(REG_IDX_W'(i), 16'hFFFF);
      send_item(OP_SET, 3'd1, 1'b1);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_SET, 3'd1, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_SET, 3'd0, 1'b1);
      send_item(OP_TICK, 3'd0, 1'b0);
      send_item(OP_SET, 3'd0, 1'b0);
      send_item(OP_TICK, 3'd0, 1'b0);
      wait_for_idle();
   endtask

   function automatic logic [DELAY_W-1:0] pick_delay(input int phase);
      if (phase == 0) return '0;
      if (phase == PHASES - 1) begin
         case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return DELAY_W'($urandom_range(0, 65535));
         endcase
      end
      if ($urandom_range(0, 99) < 85) return DELAY_W'($urandom_range(0, 7));
      return DELAY_W'($urandom_range(0, 65535));
   endfunction

   // random phases: new delays while idle, then set beats followed by tick bursts, mixed with single random beats
   task automatic test_random_phases();
      int sent;
      int burst;
      for (int p = 0; p < PHASES; p++) begin
         steady = (p == STEADY_PHASE);
         for (int i = 0; i < NUM_REGS; i++) write_delay(REG_IDX_W'(i), pick_delay(p));
         if ($urandom_range(0, 3) == 0)
            write_delay(REG_IDX_W'($urandom_range(NUM_REGS, 2 ** REG_IDX_W - 1)),
                        DELAY_W'($urandom));
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 99) < 85) begin
               send_item(OP_SET, TIDX_W'($urandom_range(0, TIMERS - 1)),
                         1'($urandom_range(0, 1)));
               sent++;
               burst = $urandom_range(1, 10);
               repeat (burst) begin
                  send_item(OP_TICK, TIDX_W'($urandom), 1'($urandom));
                  sent++;
               end
            end else begin
               send_item(1'($urandom), TIDX_W'($urandom), 1'($urandom));
               sent++;
            end
         end
         wait_for_idle();
         steady = 1'b0;
      end
   endtask

   // rsp checker and receiver stall
   always @(posedge clock) begin
      flag_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flags.size() == 0) begin
            report_error($sformatf("unexpected rsp beat on=%h off=%h",
                                   rsp_on_delayed_flags, rsp_off_delayed_flags));
         end else begin
            want = pending_flags.pop_front();
            if (rsp_on_delayed_flags !== want.on_flags)
               report_error($sformatf("on_delayed_flags got %h want %h",
                                      rsp_on_delayed_flags, want.on_flags));
            if (rsp_off_delayed_flags !== want.off_flags)
               report_error($sformatf("off_delayed_flags got %h want %h",
                                      rsp_off_delayed_flags, want.off_flags));
         end
      end
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_mirror();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_zero_delay();
      test_extreme_delays();
      test_random_phases();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
